// ===== src/cte_pkg.sv =====
// ----------------------------------------------------------------------------
// cte_pkg
// Shared constants for the causal template extractor and its channels.
// ----------------------------------------------------------------------------
package cte_pkg;

  localparam int MAX_LINE         = 4096;
  localparam int SAMPLE_BITS      = 16;
  localparam int LINE_WIDTH_BITS  = 13;
  localparam int LINE_WIDTH_RESET = 4096;

endpackage

// ===== src/cte_if.sv =====
// ----------------------------------------------------------------------------
// cte channel interfaces
// Valid/ready channels for the pixel input, the template output and the
// line width register write.
// ----------------------------------------------------------------------------
interface cte_pixel_if #(
  parameter int SAMPLE_BITS = cte_pkg::SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic                   frame_start;
  logic [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, frame_start, sample_value, input ready);
  modport sink   (input valid, frame_start, sample_value, output ready);
endinterface

interface cte_template_if #(
  parameter int SAMPLE_BITS = cte_pkg::SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_a;
  logic [SAMPLE_BITS-1:0] above_b;
  logic [SAMPLE_BITS-1:0] above_left_c;
  logic [SAMPLE_BITS-1:0] above_right_d;
  logic [SAMPLE_BITS-1:0] two_left_e;
  logic [SAMPLE_BITS-1:0] two_above_f;

  modport source (
    output valid, left_a, above_b, above_left_c, above_right_d, two_left_e, two_above_f,
    input  ready
  );
  modport sink (
    input  valid, left_a, above_b, above_left_c, above_right_d, two_left_e, two_above_f,
    output ready
  );
endinterface

interface cte_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cte_pkg::LINE_WIDTH_BITS-1:0] line_width;

  modport source (output valid, line_width, input ready);
  modport sink   (input valid, line_width, output ready);
endinterface

// ===== src/causal_template_extractor.sv =====
// ----------------------------------------------------------------------------
// causal_template_extractor
// Raster-order line buffer giving the six causal neighbours of each sample.
// ----------------------------------------------------------------------------
// usage:
//   pixel_in     : one sample word per handshake, raster order; frame_start
//                  restarts at row 0, column 0 before that sample
//   template_out : one word of six neighbours (a..f) per input word, in order
//   cfg          : line width write, taken at once (cfg.ready is always high);
//                  write it only while no word is in flight
// latency: two cycles from the edge that takes a sample to the first edge at
//   which its template word can be taken from template_out
// throughput: one word per cycle, set by the two line stores, each read
//   once and written once per cycle (row above plus older row in one store,
//   a copy of the row above in the other for the above-right read)
// reset: position goes to row 0, column 0, line width to its default, the
//   output queue is emptied; the line stores are not cleared
// stall: a three-word output queue holds finished words; pixel_in.ready
//   drops only once the queue and the word in flight would fill it
// ----------------------------------------------------------------------------
module causal_template_extractor #(
  parameter int MAX_LINE    = cte_pkg::MAX_LINE,
  parameter int SAMPLE_BITS = cte_pkg::SAMPLE_BITS
) (
  input  logic            clk,
  input  logic            rst,
  cte_cfg_if.sink         cfg,
  cte_pixel_if.sink       pixel_in,
  cte_template_if.source  template_out
);

  localparam int CW      = $clog2(MAX_LINE);
  localparam int LW      = cte_pkg::LINE_WIDTH_BITS;
  localparam int WW      = (CW + 1 > LW) ? CW + 1 : LW;
  localparam int W_RESET = (cte_pkg::LINE_WIDTH_RESET > MAX_LINE) ?
                           MAX_LINE : cte_pkg::LINE_WIDTH_RESET;
  localparam int QDEPTH  = 3;
  localparam int QW      = 2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] a;
    logic [SAMPLE_BITS-1:0] b;
    logic [SAMPLE_BITS-1:0] c;
    logic [SAMPLE_BITS-1:0] d;
    logic [SAMPLE_BITS-1:0] e;
    logic [SAMPLE_BITS-1:0] f;
  } tmpl_t;

  logic                     in_fire;
  logic                     cfg_fire;
  logic                     out_fire;

  logic [WW-1:0]            width_eff;
  logic [WW-1:0]            cfg_width_ext;

  logic [CW-1:0]            col;
  logic [CW-1:0]            col_next;
  logic [1:0]               row;
  logic [1:0]               row_next;
  logic [CW-1:0]            c_in;
  logic [CW-1:0]            c_in_inc;
  logic [1:0]               r_in;
  logic                     last_in;

  logic                     s1_valid;
  logic [CW-1:0]            s1_col;
  logic [1:0]               s1_row;
  logic                     s1_last;
  logic [SAMPLE_BITS-1:0]   s1_x;
  logic                     fwd_a;
  logic                     fwd_b;
  logic [SAMPLE_BITS-1:0]   fwd_p;
  logic [SAMPLE_BITS-1:0]   fwd_o;

  logic [2*SAMPLE_BITS-1:0] rd_a;
  logic [SAMPLE_BITS-1:0]   rd_b;
  logic [SAMPLE_BITS-1:0]   p_eff;
  logic [SAMPLE_BITS-1:0]   o_eff;
  logic [SAMPLE_BITS-1:0]   pn_eff;

  logic [SAMPLE_BITS-1:0]   left;
  logic [SAMPLE_BITS-1:0]   left2;
  logic [SAMPLE_BITS-1:0]   hold;

  tmpl_t                    tmpl;
  tmpl_t                    queue [QDEPTH];
  logic [QW-1:0]            head;
  logic [QW-1:0]            tail;
  logic [QW-1:0]            head_inc;
  logic [QW-1:0]            tail_inc;
  logic [QW-1:0]            count;

  assign in_fire  = pixel_in.valid && pixel_in.ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign out_fire = template_out.valid && template_out.ready;

  // line width register
  assign cfg.ready     = 1'b1;
  assign cfg_width_ext = WW'(cfg.line_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff <= WW'(W_RESET);
    end else if (cfg_fire) begin
      if (cfg_width_ext == '0) begin
        width_eff <= WW'(1);
      end else if (cfg_width_ext > WW'(MAX_LINE)) begin
        width_eff <= WW'(MAX_LINE);
      end else begin
        width_eff <= cfg_width_ext;
      end
    end
  end

  // position of the incoming word
  always_comb begin
    c_in     = pixel_in.frame_start ? '0 : col;
    r_in     = pixel_in.frame_start ? 2'd0 : row;
    c_in_inc = c_in + 1'b1;
    last_in  = (WW'(c_in) + WW'(1)) >= width_eff;
    if (last_in) begin
      col_next = '0;
      row_next = (r_in < 2'd2) ? r_in + 2'd1 : r_in;
    end else begin
      col_next = c_in_inc;
      row_next = r_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= 2'd0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
      if (in_fire) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  // read stage, with forwarding of the write made in the same cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col  <= c_in;
      s1_row  <= r_in;
      s1_last <= last_in;
      s1_x    <= pixel_in.sample_value;
      fwd_a   <= s1_valid && (s1_col == c_in);
      fwd_b   <= s1_valid && (s1_col == c_in_inc);
      fwd_p   <= s1_x;
      fwd_o   <= p_eff;
    end
  end

  // row above and older row, packed in one word
  cte_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (MAX_LINE)
  ) u_rows_ram (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data ({s1_x, p_eff}),
    .rd_addr (c_in),
    .rd_data (rd_a)
  );

  // copy of the row above for the above-right read
  cte_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LINE)
  ) u_ahead_ram (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (s1_x),
    .rd_addr (c_in_inc),
    .rd_data (rd_b)
  );

  assign p_eff  = fwd_a ? fwd_p : rd_a[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign o_eff  = fwd_a ? fwd_o : rd_a[SAMPLE_BITS-1:0];
  assign pn_eff = fwd_b ? fwd_p : rd_b;

  // neighbour selection with border substitution
  always_comb begin
    tmpl = '0;
    if (s1_col != '0) begin
      tmpl.a = left;
      tmpl.c = (s1_row != 2'd0) ? hold : left;
      tmpl.e = (s1_col > CW'(1)) ? left2 : tmpl.c;
    end else if (s1_row != 2'd0) begin
      tmpl.a = p_eff;
      tmpl.c = p_eff;
      tmpl.e = p_eff;
    end
    if (s1_row != 2'd0) begin
      tmpl.b = p_eff;
      tmpl.d = s1_last ? p_eff : pn_eff;
      tmpl.f = (s1_row > 2'd1) ? o_eff : p_eff;
    end else begin
      tmpl.b = tmpl.a;
      tmpl.d = tmpl.a;
      tmpl.f = tmpl.a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left  <= '0;
      left2 <= '0;
      hold  <= '0;
    end else if (s1_valid) begin
      hold  <= p_eff;
      left2 <= left;
      left  <= s1_x;
    end
  end

  // output queue
  assign head_inc = (head == QW'(QDEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == QW'(QDEPTH - 1)) ? '0 : tail + 1'b1;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      queue[tail] <= tmpl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (s1_valid) begin
        tail <= tail_inc;
      end
      if (out_fire) begin
        head <= head_inc;
      end
      count <= count + QW'(s1_valid) - QW'(out_fire);
    end
  end

  assign pixel_in.ready             = ({1'b0, count} + {2'b00, s1_valid}) < 3'(QDEPTH);
  assign template_out.valid         = count != '0;
  assign template_out.left_a        = queue[head].a;
  assign template_out.above_b       = queue[head].b;
  assign template_out.above_left_c  = queue[head].c;
  assign template_out.above_right_d = queue[head].d;
  assign template_out.two_left_e    = queue[head].e;
  assign template_out.two_above_f   = queue[head].f;

`ifndef ASSERT_OFF
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (count != QW'(QDEPTH)) || out_fire)
    else $error("template queue overrun");

  a_first_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_col == '0 && s1_row == 2'd0) |-> tmpl == '0)
    else $error("first pixel of frame gave a non-zero template");

  a_row0_copies_left: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_row == 2'd0) |->
      (tmpl.b == tmpl.a && tmpl.d == tmpl.a && tmpl.f == tmpl.a))
    else $error("top row border rule broken");

  a_row_monotone: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !pixel_in.frame_start) |=> row >= $past(row))
    else $error("row position went back without frame start");
`endif

endmodule

// ===== src/cte_ram.sv =====
// ----------------------------------------------------------------------------
// cte_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
